[src/bounded_size_priority_task_queue_assert.svh]
// Assertion macros shared by the queue RTL
`ifndef BOUNDED_SIZE_PRIORITY_TASK_QUEUE_ASSERT_SVH
`define BOUNDED_SIZE_PRIORITY_TASK_QUEUE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define BSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define BSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/bsq_pkg.sv]
// ----------------------------------------------------------------------------
// bsq_pkg
// Types and constants of the bounded size-priority task queue.
// ----------------------------------------------------------------------------
package bsq_pkg;
    localparam int QUEUE_DEPTH = 256;
    localparam int SIZE_BITS   = 48;
    localparam int TAG_BITS    = 16;
    localparam int TGT_BITS    = 13;
    localparam int ORD_BITS    = 64;
    localparam int THR_BITS    = 31;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_BITS    = SIZE_BITS + ORD_BITS + TAG_BITS + TGT_BITS;

    localparam logic [THR_BITS-1:0] THRESH_RESET = 31'd52428800;

    localparam logic       CMD_PUSH = 1'b0;
    localparam logic       CMD_POP  = 1'b1;

    localparam logic [1:0] EV_DISPATCH = 2'd0;
    localparam logic [1:0] EV_EMPTY    = 2'd1;
    localparam logic [1:0] EV_STALE    = 2'd2;
    localparam logic [1:0] EV_FAIL     = 2'd3;

    typedef struct packed {
        logic [SIZE_BITS-1:0] job_size;
        logic [ORD_BITS-1:0]  order;
        logic [TAG_BITS-1:0]  tag;
        logic [TGT_BITS-1:0]  target;
    } entry_t;

    typedef struct packed {
        logic       command;
        logic [47:0] job_size;
        logic [15:0] request_tag;
        logic [12:0] target_size;
        logic        supported;
    } req_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [15:0] out_tag;
        logic [12:0] out_target_size;
        logic [47:0] out_job_size;
        logic        degrade;
        logic [8:0]  occupancy;
    } res_t;
endpackage

[src/bsq_if.sv]
// ----------------------------------------------------------------------------
// bsq_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface bsq_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[src/bsq_ram.sv]
// ----------------------------------------------------------------------------
// bsq_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module bsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/bounded_size_priority_task_queue.sv]
// Bounded size-priority task queue. Entries live in one RAM, appended at the
// end and compacted by moving the last entry into a removed slot. A push with
// room, an unsupported push and a pop on an empty queue are answered from
// idle without a scan. A pop or a push into a full queue scans all stored
// entries with one RAM read per cycle, then reads the last entry, moves it
// into the removed slot and waits to hand over the result. A full-queue push
// whose new job is rejected skips the move. One item is processed at a time.
// The result waits in an output register. The next beat is taken in idle once
// that result has been taken, or is being taken in the same cycle.
// ----------------------------------------------------------------------------
// bounded_size_priority_task_queue
// Top level: request sequencer around the entry RAM.
// ----------------------------------------------------------------------------
`include "bounded_size_priority_task_queue_assert.svh"
module bounded_size_priority_task_queue
    import bsq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bsq_if.sink                   req,
    bsq_if.source                 res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [THR_BITS-1:0]   cfg_data
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [THR_BITS-1:0] thr_reg;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [ORD_BITS-1:0] order_reg, order_next;
    req_t                cur_reg, cur_next;
    logic [CNT_BITS-1:0] rptr_reg, rptr_next;
    logic [CNT_BITS-1:0] cptr_reg, cptr_next;
    entry_t              best_reg, best_next;
    logic [IDX_BITS-1:0] bidx_reg, bidx_next;
    logic                bvalid_reg, bvalid_next;
    res_t                out_reg, out_next;
    logic                ovalid_reg, ovalid_next;

    logic                we;
    logic [IDX_BITS-1:0] waddr, raddr;
    entry_t              wdata, rdata;
    logic                rd_pending_reg, rd_pending_next;
    logic                better;
    logic                is_pop;

    bsq_ram #(.WIDTH(ENT_BITS), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign cfg_ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE) && !(ovalid_reg && !res.ready);
    assign res.valid = ovalid_reg;
    assign res.data  = out_reg;
    assign is_pop    = (cur_reg.command == CMD_POP);

    always_comb
    begin
        if (is_pop)
        begin
            better = (rdata.job_size < best_reg.job_size) ||
                     ((rdata.job_size == best_reg.job_size) &&
                      (rdata.order < best_reg.order));
        end
        else
        begin
            better = (rdata.job_size > best_reg.job_size) ||
                     ((rdata.job_size == best_reg.job_size) &&
                      (rdata.order > best_reg.order));
        end
        if (!bvalid_reg)
        begin
            better = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        order_next      = order_reg;
        cur_next        = cur_reg;
        rptr_next       = rptr_reg;
        cptr_next       = cptr_reg;
        best_next       = best_reg;
        bidx_next       = bidx_reg;
        bvalid_next     = bvalid_reg;
        out_next        = out_reg;
        ovalid_next     = ovalid_reg && !res.ready;
        rd_pending_next = 1'b0;
        we              = 1'b0;
        waddr           = '0;
        wdata           = '0;
        raddr           = rptr_reg[IDX_BITS-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    cur_next    = req.data;
                    rptr_next   = '0;
                    cptr_next   = '0;
                    bvalid_next = 1'b0;
                    if (req.data.command == CMD_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            out_next = '0;
                            out_next.event_res = EV_EMPTY;
                            ovalid_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (!req.data.supported)
                    begin
                        out_next = '0;
                        out_next.event_res    = EV_FAIL;
                        out_next.out_tag      = req.data.request_tag;
                        out_next.out_job_size = req.data.job_size;
                        out_next.occupancy    = count_reg;
                        ovalid_next = 1'b1;
                    end
                    else
                    begin
                        order_next = order_reg + 1'b1;
                        if (count_reg == CNT_BITS'(QUEUE_DEPTH))
                        begin
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            we    = 1'b1;
                            waddr = count_reg[IDX_BITS-1:0];
                            wdata = '{req.data.job_size, order_reg,
                                      req.data.request_tag, req.data.target_size};
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (rptr_reg < count_reg)
                begin
                    raddr           = rptr_reg[IDX_BITS-1:0];
                    rd_pending_next = 1'b1;
                    rptr_next       = rptr_reg + 1'b1;
                end
                if (rd_pending_reg)
                begin
                    if (better)
                    begin
                        best_next   = rdata;
                        bidx_next   = cptr_reg[IDX_BITS-1:0];
                        bvalid_next = 1'b1;
                    end
                    cptr_next = cptr_reg + 1'b1;
                    if (cptr_reg + 1'b1 == count_reg)
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                // read the last entry for compaction
                raddr = IDX_BITS'(count_reg - 1'b1);
                out_next = '0;
                if (is_pop)
                begin
                    out_next.event_res       = EV_DISPATCH;
                    out_next.out_tag         = best_reg.tag;
                    out_next.out_target_size = best_reg.target;
                    out_next.out_job_size    = best_reg.job_size;
                    out_next.degrade = (best_reg.job_size >= {17'd0, thr_reg});
                    out_next.occupancy       = count_reg - 1'b1;
                    state_next = S_MOVE;
                end
                else if (best_reg.job_size > cur_reg.job_size)
                begin
                    out_next.event_res    = EV_STALE;
                    out_next.out_tag      = best_reg.tag;
                    out_next.out_job_size = best_reg.job_size;
                    out_next.occupancy    = count_reg;
                    state_next = S_MOVE;
                end
                else
                begin
                    out_next.event_res    = EV_STALE;
                    out_next.out_tag      = cur_reg.request_tag;
                    out_next.out_job_size = cur_reg.job_size;
                    out_next.occupancy    = count_reg;
                    state_next = S_WAIT;
                end
            end
            S_MOVE:
            begin
                we    = 1'b1;
                waddr = bidx_reg;
                wdata = rdata;
                if (is_pop)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    // then append new entry at count-1
                    state_next = S_WAIT;
                    cptr_next  = '1;
                end
            end
            S_WAIT:
            begin
                if (!is_pop && cptr_reg == '1)
                begin
                    we    = 1'b1;
                    waddr = IDX_BITS'(count_reg - 1'b1);
                    wdata = '{cur_reg.job_size, order_reg - 1'b1,
                              cur_reg.request_tag, cur_reg.target_size};
                end
                if (!ovalid_reg || res.ready)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                cptr_next = '0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thr_reg        <= THRESH_RESET;
            count_reg      <= '0;
            order_reg      <= '0;
            ovalid_reg     <= 1'b0;
            rd_pending_reg <= 1'b0;
            bvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            order_reg      <= order_next;
            ovalid_reg     <= ovalid_next;
            rd_pending_reg <= rd_pending_next;
            bvalid_reg     <= bvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        rptr_reg <= rptr_next;
        cptr_reg <= cptr_next;
        best_reg <= best_next;
        bidx_reg <= bidx_next;
        out_reg  <= out_next;
    end

    `BSQ_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= CNT_BITS'(QUEUE_DEPTH))
    `BSQ_ASSERT_IMPL(a_busy_no_accept, clk, rst_n, state_reg != S_IDLE, !req.ready)
    `BSQ_ASSERT_NEXT(a_pop_count, clk, rst_n,
        state_reg == S_MOVE && is_pop, count_reg == $past(count_reg) - 1'b1)
endmodule

[tb/sv/tb_bsq_checker.sv]
// ----------------------------------------------------------------------------
// tb_bsq_checker
// Watches the request, result and threshold channels of the task queue,
// keeps its own image of the stored jobs and compares every result beat.
// ----------------------------------------------------------------------------
module tb_bsq_checker
    import bsq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  req_t                req_data,
    input  logic                res_valid,
    input  logic                res_ready,
    input  res_t                res_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [THR_BITS-1:0] cfg_data,
    output int                  errors,
    output int                  pending,
    output int                  occ_now
);
    timeunit 1ns;
    timeprecision 1ps;

    entry_t               jobs[$];
    res_t                 awaited[$];
    logic [ORD_BITS-1:0]  order_cnt;
    logic [THR_BITS-1:0]  threshold;

    function automatic res_t mk(logic [1:0] ev, logic [15:0] tg, logic [12:0] tt,
                                logic [47:0] sz, logic dg);
        res_t r;
        r.event_res = ev;
        r.out_tag = tg;
        r.out_target_size = tt;
        r.out_job_size = sz;
        r.degrade = dg;
        r.occupancy = 9'(jobs.size());
        return r;
    endfunction

    task automatic expect_beat(res_t r);
        awaited.insert(awaited.size(), r);
    endtask

    task automatic drop_last_job;
        jobs.delete(jobs.size() - 1);
    endtask

    task automatic append_job(entry_t e);
        jobs.insert(jobs.size(), e);
    endtask

    task automatic queue_step(req_t q);
        int     b;
        entry_t e;
        if (q.command == CMD_POP)
        begin
            if (jobs.size() == 0)
            begin
                expect_beat(mk(EV_EMPTY, '0, '0, '0, 1'b0));
                return;
            end
            b = 0;
            for (int i = 1; i < jobs.size(); i++)
                if (jobs[i].job_size < jobs[b].job_size ||
                    (jobs[i].job_size == jobs[b].job_size && jobs[i].order < jobs[b].order))
                    b = i;
            e = jobs[b];
            jobs[b] = jobs[jobs.size()-1];
            drop_last_job();
            expect_beat(mk(EV_DISPATCH, e.tag, e.target, e.job_size,
                           e.job_size >= {17'd0, threshold}));
            return;
        end
        if (!q.supported)
        begin
            expect_beat(mk(EV_FAIL, q.request_tag, '0, q.job_size, 1'b0));
            return;
        end
        e.job_size = q.job_size;
        e.order = order_cnt;
        e.tag = q.request_tag;
        e.target = q.target_size;
        order_cnt++;
        if (jobs.size() >= QUEUE_DEPTH)
        begin
            b = 0;
            for (int i = 1; i < jobs.size(); i++)
                if (jobs[i].job_size > jobs[b].job_size ||
                    (jobs[i].job_size == jobs[b].job_size && jobs[i].order > jobs[b].order))
                    b = i;
            if (jobs[b].job_size > q.job_size)
            begin
                entry_t d;
                d = jobs[b];
                jobs[b] = jobs[jobs.size()-1];
                drop_last_job();
                append_job(e);
                expect_beat(mk(EV_STALE, d.tag, '0, d.job_size, 1'b0));
            end
            else
                expect_beat(mk(EV_STALE, q.request_tag, '0, q.job_size, 1'b0));
        end
        else
            append_job(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jobs.delete();
            awaited.delete();
            order_cnt = '0;
            threshold <= THRESH_RESET;
            errors <= 0;
            pending <= 0;
            occ_now <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                threshold <= cfg_data;
            if (res_valid && res_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result beat with nothing outstanding");
                    errors <= errors + 1;
                end
                else
                begin
                    res_t x;
                    int   n;
                    x = awaited.pop_front();
                    n = 0;
                    if (x.event_res !== res_data.event_res)
                    begin
                        $error("event_res exp %0d got %0d", x.event_res, res_data.event_res);
                        n++;
                    end
                    if (x.out_tag !== res_data.out_tag)
                    begin
                        $error("out_tag exp %0h got %0h", x.out_tag, res_data.out_tag);
                        n++;
                    end
                    if (x.out_target_size !== res_data.out_target_size)
                    begin
                        $error("out_target_size exp %0d got %0d", x.out_target_size,
                               res_data.out_target_size);
                        n++;
                    end
                    if (x.out_job_size !== res_data.out_job_size)
                    begin
                        $error("out_job_size exp %0h got %0h", x.out_job_size,
                               res_data.out_job_size);
                        n++;
                    end
                    if (x.degrade !== res_data.degrade)
                    begin
                        $error("degrade exp %0d got %0d", x.degrade, res_data.degrade);
                        n++;
                    end
                    if (x.occupancy !== res_data.occupancy)
                    begin
                        $error("occupancy exp %0d got %0d", x.occupancy, res_data.occupancy);
                        n++;
                    end
                    if (n != 0)
                        errors <= errors + 1;
                end
            end
            if (req_valid && req_ready)
                queue_step(req_data);
            pending <= awaited.size();
            occ_now <= jobs.size();
        end
    end
endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bounded task queue: directed pushes and pops, queue fill
// with evictions, threshold changes at idle points, then random traffic with
// random gaps on both sides. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
    import bsq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [THR_BITS-1:0] cfg_data = '0;
    logic cfg_ready;
    int   errors, pending, occ_now;
    int   idle_cycles = 0;
    int   n_push = 0, n_pop = 0, n_res = 0;
    bit   hold_res = 1'b0;

    bsq_if #(.payload_t(req_t)) req_ch();
    bsq_if #(.payload_t(res_t)) res_ch();

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bounded_size_priority_task_queue dut (
        .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .res(res_ch.source),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    tb_bsq_checker chk (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
        .res_valid(res_ch.valid), .res_ready(res_ch.ready), .res_data(res_ch.data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .occ_now(occ_now)
    );

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        res_ch.ready = 1'b0;
    end

    // receiver: random stall per beat
    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            w = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0 || hold_res)
                w = 0;
            if (w != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (res_ch.valid && res_ch.ready)
            n_res <= n_res + 1;
        if (idle_cycles > 4000)
        begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send(logic cmd, logic [47:0] sz, logic [15:0] tg, logic [12:0] tt,
                        logic sup, bit gaps);
        req_t q;
        int   w;
        q.command = cmd;
        q.job_size = sz;
        q.request_tag = tg;
        q.target_size = tt;
        q.supported = sup;
        w = gaps ? int'($urandom_range(0, 8)) : 0;
        if (w != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (w) @(negedge clk);
        end
        req_ch.data <= q;
        req_ch.valid <= 1'b1;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
        if (cmd == CMD_POP)
            n_pop++;
        else
            n_push++;
    endtask

    task automatic drain;
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic set_threshold(logic [THR_BITS-1:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [47:0] rnd_size;
        logic [47:0] s;
        s = 48'({$urandom, $urandom});
        case ($urandom_range(0, 4))
            0: s = s & 48'hFF;
            1: s = s & 48'h7FFFFFFF;
            2: s = 48'($urandom_range(0, 7)) * 48'd20000000;
            default: ;
        endcase
        return s;
    endfunction

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty pop, extremes, unsupported, ties
        send(CMD_POP, 48'hFFFFFFFFFFFF, 16'hFFFF, 13'h1FFF, 1'b1, 1'b0);
        send(CMD_PUSH, 48'hFFFFFFFFFFFF, 16'hFFFF, 13'h1FFF, 1'b0, 1'b0);
        send(CMD_PUSH, 48'hFFFFFFFFFFFF, 16'hFFFF, 13'h1FFF, 1'b1, 1'b0);
        send(CMD_PUSH, 48'd0, 16'd0, 13'd0, 1'b1, 1'b0);
        send(CMD_PUSH, 48'd52428800, 16'd1, 13'd4096, 1'b1, 1'b0);
        send(CMD_PUSH, 48'd52428799, 16'd2, 13'd1, 1'b1, 1'b0);
        send(CMD_PUSH, 48'd52428800, 16'd3, 13'd7, 1'b1, 1'b0);
        repeat (6) send(CMD_POP, '0, '0, '0, 1'b0, 1'b0);

        // fill past full: evictions and stale rejections, ties at the top
        set_threshold(31'd0);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send(CMD_PUSH, (i % 3 == 0) ? 48'd1000 : 48'($urandom_range(0, 999)),
                 16'(i), 13'(i), 1'b1, 1'b0);
        send(CMD_PUSH, 48'd1000, 16'hAAAA, 13'd5, 1'b1, 1'b0);
        send(CMD_PUSH, 48'd5, 16'h5555, 13'd6, 1'b1, 1'b0);
        send(CMD_PUSH, 48'hFFFFFFFFFFFF, 16'h1234, 13'd9, 1'b1, 1'b0);
        send(CMD_PUSH, 48'd0, 16'h4321, 13'd9, 1'b0, 1'b0);
        set_threshold(31'h7FFFFFFF);
        for (int i = 0; i < 40; i++)
            send(CMD_POP, '0, '0, '0, 1'b1, 1'b1);

        // random traffic, threshold changes between phases
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                1: set_threshold(31'd1048576);
                2: set_threshold(31'd1073741824);
                3: set_threshold(31'($urandom));
                5: set_threshold(31'd52428800);
                default: ;
            endcase
            hold_res = (ph == 4);
            for (int i = 0; i < 160; i++)
            begin
                logic cmd;
                int   pp;
                pp = (ph == 6) ? 20 : (occ_now > 200 ? 60 : 40);
                cmd = ($urandom_range(0, 99) < pp) ? CMD_POP : CMD_PUSH;
                send(cmd, rnd_size(), 16'($urandom), 13'($urandom),
                     $urandom_range(0, 9) != 0, ($urandom_range(0, 4) != 0));
                if (i == 80)
                    drain();
            end
        end

        drain();
        $display("pushes %0d, pops %0d, results %0d, final occupancy %0d",
                 n_push, n_pop, n_res, occ_now);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
